/* sv/ddwsl_pkg.sv */
`timescale 1ns / 1ps

package ddwsl_pkg;

  // Wheel order inside every four-wide vector
  localparam int W_LO = 0;
  localparam int W_LI = 1;
  localparam int W_RO = 2;
  localparam int W_RI = 3;
  localparam int NWHEEL = 4;

  // Configuration register indexes
  localparam logic [1:0] REG_IHW = 2'd0;
  localparam logic [1:0] REG_OCD = 2'd1;
  localparam logic [1:0] REG_L2A = 2'd2;
  localparam logic [1:0] REG_LIM = 2'd3;

  // Pipeline shape
  localparam int KIN_STG = 6;
  localparam int QB      = 17;             // quotient bits
  localparam int DIV_STG = QB + 1;         // range check plus one stage per quotient bit
  localparam int NSTG    = KIN_STG + DIV_STG + 1;

  // Datapath widths
  localparam int MAG_W = 28;               // |speed| before limiting
  localparam int NUM_W = MAG_W + 16;       // |speed| * limit
  localparam int REM_W = MAG_W + QB;       // partial remainder
  localparam int OUT_W = 17;

  localparam logic [15:0] SAT = 16'hFFFF;

  typedef struct packed {
    logic [15:0] ihw;
    logic [15:0] ocd;
    logic [15:0] l2a;
    logic [15:0] lim;
  } cfg_t;

endpackage

/* sv/ddwsl_kin.sv */
`timescale 1ns / 1ps

module ddwsl_kin (
  input  logic                                      clk_i,
  input  logic [ddwsl_pkg::KIN_STG-1:0]             en_i,
  input  ddwsl_pkg::cfg_t                           cfg_i,
  input  logic signed [15:0]                        fwd_i,
  input  logic signed [15:0]                        turn_i,
  output logic [ddwsl_pkg::NWHEEL-1:0]              sign_o,
  output logic [ddwsl_pkg::NWHEEL-1:0][ddwsl_pkg::MAG_W-1:0] mag_o,
  output logic [ddwsl_pkg::NWHEEL-1:0][ddwsl_pkg::NUM_W-1:0] num_o,
  output logic [ddwsl_pkg::MAG_W-1:0]               den_o,
  output logic                                      limited_o
);
  import ddwsl_pkg::*;

  logic signed [15:0]        fwd_q;
  logic signed [31:0]        offo_q, offi_q;
  logic signed [32:0]        sum_q  [NWHEEL];
  logic signed [48:0]        prod_q [NWHEEL];
  logic signed [28:0]        spd_q  [NWHEEL];
  logic [NWHEEL-1:0]         sgn4_q;
  logic [MAG_W-1:0]          mag4_q [NWHEEL];
  logic [NWHEEL-1:0]         sgn5_q;
  logic [MAG_W-1:0]          mag5_q [NWHEEL];
  logic [NUM_W-1:0]          num5_q [NWHEEL];
  logic [MAG_W-1:0]          den5_q;
  logic                      lim5_q;
  logic [MAG_W-1:0]          max_d;

  assign max_d = (mag4_q[W_LO] > mag4_q[W_RO]) ? mag4_q[W_LO] : mag4_q[W_RO];

  always_ff @(posedge clk_i) begin
    // stage 0: wheel offsets
    if (en_i[0]) begin
      fwd_q  <= fwd_i;
      offo_q <= 32'(turn_i * $signed({1'b0, cfg_i.ocd}));
      offi_q <= 32'(turn_i * $signed({1'b0, cfg_i.ihw}));
    end
    // stage 1: forward speed minus or plus offset
    if (en_i[1]) begin
      sum_q[W_LO] <= (33'(fwd_q) <<< 12) - 33'(offo_q);
      sum_q[W_LI] <= (33'(fwd_q) <<< 12) - 33'(offi_q);
      sum_q[W_RO] <= (33'(fwd_q) <<< 12) + 33'(offo_q);
      sum_q[W_RI] <= (33'(fwd_q) <<< 12) + 33'(offi_q);
    end
    for (int i = 0; i < NWHEEL; i++) begin
      // stage 2: scale to angular speed
      if (en_i[2]) prod_q[i] <= 49'(sum_q[i] * $signed({1'b0, cfg_i.l2a}));
      // stage 3: drop 20 fraction bits, rounding toward zero
      if (en_i[3]) begin
        spd_q[i] <= 29'((prod_q[i] + (prod_q[i][48] ? 49'sd1048575 : 49'sd0)) >>> 20);
      end
      // stage 4: split into sign and magnitude
      if (en_i[4]) begin
        sgn4_q[i] <= spd_q[i][28];
        mag4_q[i] <= spd_q[i][28] ? MAG_W'(-spd_q[i]) : MAG_W'(spd_q[i]);
      end
      // stage 5: numerator for the ratio-keeping scale
      if (en_i[5]) begin
        sgn5_q[i] <= sgn4_q[i];
        mag5_q[i] <= mag4_q[i];
        num5_q[i] <= NUM_W'(mag4_q[i] * cfg_i.lim);
      end
    end
    // stage 5: larger outer speed against the limit
    if (en_i[5]) begin
      den5_q <= max_d;
      lim5_q <= max_d > MAG_W'(cfg_i.lim);
    end
  end

  always_comb begin
    for (int i = 0; i < NWHEEL; i++) begin
      sign_o[i] = sgn5_q[i];
      mag_o[i]  = mag5_q[i];
      num_o[i]  = num5_q[i];
    end
  end

  assign den_o     = den5_q;
  assign limited_o = lim5_q;

endmodule

/* sv/ddwsl_div_lane.sv */
`timescale 1ns / 1ps

module ddwsl_div_lane (
  input  logic                               clk_i,
  input  logic [ddwsl_pkg::DIV_STG-1:0]      en_i,
  input  logic                               sign_i,
  input  logic [ddwsl_pkg::MAG_W-1:0]        mag_i,
  input  logic [ddwsl_pkg::NUM_W-1:0]        num_i,
  input  logic [ddwsl_pkg::MAG_W-1:0]        den_i,
  input  logic                               limited_i,
  output logic signed [ddwsl_pkg::OUT_W-1:0] res_o,
  output logic                               limited_o
);
  import ddwsl_pkg::*;

  logic              sg_q  [DIV_STG];
  logic              lf_q  [DIV_STG];
  logic              ovf_q [DIV_STG];
  logic [15:0]       vs_q  [DIV_STG];
  logic [MAG_W-1:0]  d_q   [DIV_STG];
  logic [REM_W-1:0]  r_q   [DIV_STG];
  logic [QB-1:0]     q_q   [DIV_STG];
  logic [15:0]       mag_d;

  always_ff @(posedge clk_i) begin
    // range check: quotient above the 17-bit field saturates
    if (en_i[0]) begin
      sg_q[0]  <= sign_i;
      lf_q[0]  <= limited_i;
      vs_q[0]  <= (mag_i > MAG_W'(SAT)) ? SAT : mag_i[15:0];
      d_q[0]   <= den_i;
      ovf_q[0] <= REM_W'(num_i) >= (REM_W'(den_i) << QB);
      r_q[0]   <= REM_W'(num_i);
      q_q[0]   <= '0;
    end
    // one restoring step per stage, most significant quotient bit first
    for (int j = 1; j < DIV_STG; j++) begin
      if (en_i[j]) begin
        sg_q[j]  <= sg_q[j-1];
        lf_q[j]  <= lf_q[j-1];
        vs_q[j]  <= vs_q[j-1];
        d_q[j]   <= d_q[j-1];
        ovf_q[j] <= ovf_q[j-1];
        if (r_q[j-1] >= (REM_W'(d_q[j-1]) << (QB - j))) begin
          r_q[j] <= r_q[j-1] - (REM_W'(d_q[j-1]) << (QB - j));
          q_q[j] <= q_q[j-1] | (QB'(1) << (QB - j));
        end else begin
          r_q[j] <= r_q[j-1];
          q_q[j] <= q_q[j-1];
        end
      end
    end
  end

  // pick scaled or plain speed, clamp, restore sign
  always_comb begin
    if (!lf_q[DIV_STG-1]) begin
      mag_d = vs_q[DIV_STG-1];
    end else if (ovf_q[DIV_STG-1] || q_q[DIV_STG-1][QB-1]) begin
      mag_d = SAT;
    end else begin
      mag_d = q_q[DIV_STG-1][15:0];
    end
  end

  assign res_o     = sg_q[DIV_STG-1] ? -$signed({1'b0, mag_d}) : $signed({1'b0, mag_d});
  assign limited_o = lf_q[DIV_STG-1];

endmodule

/* sv/diff_drive_wheel_speed_limiter.sv */
`timescale 1ns / 1ps

// Four-wheel skid-steer inverse kinematics with a ratio-keeping speed limit.
// Each request carries a forward speed and a turn rate (both signed Q7.8);
// each result carries the four wheel speeds (signed Q8.8, clamped to
// +/-65535) and a flag that says the speeds were scaled down to the limit.
// The datapath is a 25-stage pipeline: six kinematics stages (offset
// multiply, sum, angular scale, truncation, magnitude, limit compare and
// numerator multiply), eighteen divider stages (a range check, then one
// quotient bit per stage for seventeen stages), and the output register.
// A new request is taken every cycle, and a stalled output only holds back
// the stages behind it once the bubbles in between have filled. Write
// configuration only while no request is in flight.

module diff_drive_wheel_speed_limiter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // forward_speed[15:0], turn_rate[31:16]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // left_outer_speed[16:0], left_inner_speed[33:17],
                                      // right_outer_speed[50:34], right_inner_speed[67:51],
                                      // was_limited[68], zero fill[71:69]
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i
);
  import ddwsl_pkg::*;

  cfg_t                          cfg_q;
  logic [NSTG-1:0]               vld_q;
  logic [NSTG:0]                 adv;
  logic [NWHEEL-1:0]             k_sign;
  logic [NWHEEL-1:0][MAG_W-1:0]  k_mag;
  logic [NWHEEL-1:0][NUM_W-1:0]  k_num;
  logic [MAG_W-1:0]              k_den;
  logic                          k_lim;
  logic signed [OUT_W-1:0]       lane_res [NWHEEL];
  logic [NWHEEL-1:0]             lane_lim;
  logic signed [OUT_W-1:0]       res_q [NWHEEL];
  logic                          lim_q;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ihw <= 16'd0;
      cfg_q.ocd <= 16'd0;
      cfg_q.l2a <= 16'd256;
      cfg_q.lim <= 16'hFFFF;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_IHW: cfg_q.ihw <= cfg_data_i;
        REG_OCD: cfg_q.ocd <= cfg_data_i;
        REG_L2A: cfg_q.l2a <= cfg_data_i;
        REG_LIM: cfg_q.lim <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // advance a stage when it is empty or the stage after it advances
  always_comb begin
    adv[NSTG] = m_axis_tready;
    for (int k = NSTG - 1; k >= 0; k--) begin
      adv[k] = !vld_q[k] || adv[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (adv[0]) vld_q[0] <= s_axis_tvalid;
      for (int k = 1; k < NSTG; k++) begin
        if (adv[k]) vld_q[k] <= vld_q[k-1];
      end
    end
  end

  assign s_axis_tready = adv[0];

  ddwsl_kin u_kin (
    .clk_i     (clk_i),
    .en_i      (adv[KIN_STG-1:0]),
    .cfg_i     (cfg_q),
    .fwd_i     ($signed(s_axis_tdata[15:0])),
    .turn_i    ($signed(s_axis_tdata[31:16])),
    .sign_o    (k_sign),
    .mag_o     (k_mag),
    .num_o     (k_num),
    .den_o     (k_den),
    .limited_o (k_lim)
  );

  for (genvar w = 0; w < NWHEEL; w++) begin : g_lane
    ddwsl_div_lane u_lane (
      .clk_i     (clk_i),
      .en_i      (adv[KIN_STG+DIV_STG-1:KIN_STG]),
      .sign_i    (k_sign[w]),
      .mag_i     (k_mag[w]),
      .num_i     (k_num[w]),
      .den_i     (k_den),
      .limited_i (k_lim),
      .res_o     (lane_res[w]),
      .limited_o (lane_lim[w])
    );
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (adv[NSTG-1]) begin
      for (int w = 0; w < NWHEEL; w++) res_q[w] <= lane_res[w];
      lim_q <= lane_lim[W_LO];
    end
  end

  assign m_axis_tvalid = vld_q[NSTG-1];
  assign m_axis_tdata  = {3'b000, lim_q, res_q[W_RI], res_q[W_RO], res_q[W_LI], res_q[W_LO]};

`ifndef SYNTHESIS
  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (&vld_q))
    else $error("input stalled with a bubble in the pipeline");

  a_occupancy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(vld_q) <= $past($countones(vld_q)) + 1) &&
    ($countones(vld_q) + 1 >= $past($countones(vld_q))))
    else $error("pipeline occupancy jumped by more than one");

  a_outer_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && lim_q) |->
      ((res_q[W_LO] >= 0 ? res_q[W_LO] : -res_q[W_LO]) <= $signed({1'b0, cfg_q.lim})) &&
      ((res_q[W_RO] >= 0 ? res_q[W_RO] : -res_q[W_RO]) <= $signed({1'b0, cfg_q.lim})))
    else $error("limited outer speed above the speed limit");

  a_zero_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && lim_q && cfg_q.lim == 16'd0) |->
      (res_q[W_LO] == 0 && res_q[W_LI] == 0 && res_q[W_RO] == 0 && res_q[W_RI] == 0))
    else $error("zero limit left a nonzero speed");
`endif

endmodule
